FILE: sv/spearman_rank_correlation_defines.svh
`ifndef SPEARMAN_RANK_CORRELATION_DEFINES_SVH
`define SPEARMAN_RANK_CORRELATION_DEFINES_SVH

// Assertion shorthands for the controller; clk and arst_n must be in scope.

// The consequent must hold in the same cycle as the antecedent.
`define SRCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srcc assertion failed");

`endif

FILE: sv/srcc_pkg.sv
package srcc_pkg;

	localparam int RANK_W = 12;
	localparam int RHO_W = 16;
	// Quotient bits kept by the divider; a quotient of 2^QUO_W or more saturates.
	localparam int QUO_W = 15;
	localparam int STEP_W = 4;

	localparam logic [RHO_W-1:0] RHO_ONE = 16'h4000;
	localparam logic [RHO_W-1:0] RHO_MIN = 16'hC000;

	typedef struct packed {
		logic acc;       // add the accepted pair to the running sums
		logic snap;      // last pair: move the totals to the divider, clear the sums
		logic mul1;      // n * n
		logic mul2;      // n * (n * n - 1) and the scaled numerator
		logic div_init;  // saturation check and divisor alignment
		logic div_step;  // one restoring division step
		logic out_load;  // load the result register
	} srcc_cmd_t;

	typedef struct packed {
		logic few;       // the set held fewer than two pairs
	} srcc_stat_t;

endpackage

FILE: sv/spearman_rank_correlation.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    rank_x[11:0], rank_y[11:0], last
// result    out        out_valid/out_stall  rho[15:0] signed, too_few_points
//
// Pairs without the last flag are summed at one per cycle while in_stall is low.
// A last pair starts two multiplies, a saturation check and a 15-step restoring
// divider (skipped for under two pairs); in_stall is high until the result is loaded.
// The result waits in an output register while the next set accumulates; a further
// last pair is still taken, but in_stall then stays high until that register is free.
// Reset clears the running sums, the controller and the result valid.
module spearman_rank_correlation #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [srcc_pkg::RANK_W-1:0]        rank_x,
	input  logic [srcc_pkg::RANK_W-1:0]        rank_y,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [srcc_pkg::RHO_W-1:0]  rho,
	output logic                               too_few_points
);

	srcc_pkg::srcc_cmd_t   cmd;
	srcc_pkg::srcc_stat_t  stat;

	srcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	srcc_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.rank_x         (rank_x),
		.rank_y         (rank_y),
		.rho            (rho),
		.too_few_points (too_few_points)
	);

endmodule

FILE: sv/srcc_dp.sv
module srcc_dp #(
	parameter int MAX_POINTS = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  srcc_pkg::srcc_cmd_t                cmd,
	output srcc_pkg::srcc_stat_t               stat,
	input  logic [srcc_pkg::RANK_W-1:0]        rank_x,
	input  logic [srcc_pkg::RANK_W-1:0]        rank_y,
	output logic signed [srcc_pkg::RHO_W-1:0]  rho,
	output logic                               too_few_points
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SQ_W = 2 * srcc_pkg::RANK_W;
	localparam int SUM_W = SQ_W + CNT_W;
	localparam int NSQ_W = 2 * CNT_W;
	localparam int DEN_W = 3 * CNT_W;
	localparam int NUM_W = SUM_W + 2 + srcc_pkg::QUO_W;
	localparam int DIV_W = (NUM_W > DEN_W + srcc_pkg::QUO_W) ? NUM_W
		: DEN_W + srcc_pkg::QUO_W;

	logic [CNT_W-1:0]                 cnt_q;
	logic [SUM_W-1:0]                 sum_q;
	logic [CNT_W-1:0]                 n_q;
	logic [SUM_W-1:0]                 s_q;
	logic [NSQ_W-1:0]                 nsq_q;
	logic [DEN_W-1:0]                 den_q;
	logic [DIV_W-1:0]                 rem_q;
	logic [DIV_W-1:0]                 dsh_q;
	logic [srcc_pkg::QUO_W-1:0]       quot_q;
	logic                             sat_q;
	logic [srcc_pkg::RHO_W-1:0]       rho_q;
	logic                             few_q;

	logic [srcc_pkg::RANK_W-1:0]      diff;
	logic [SQ_W-1:0]                  sq;
	logic                             room;
	logic [SUM_W-1:0]                 sum_nx;
	logic [CNT_W-1:0]                 cnt_nx;
	logic [NSQ_W-1:0]                 n_ext2;
	logic [DEN_W-1:0]                 n_ext3;
	logic [DEN_W-1:0]                 nsqm1_ext;
	logic [SUM_W+1:0]                 num3;
	logic [DIV_W-1:0]                 den_ext;
	logic                             ge;

	assign diff = (rank_x >= rank_y) ? rank_x - rank_y : rank_y - rank_x;
	assign sq = SQ_W'(diff) * SQ_W'(diff);
	// Pairs past the capacity are dropped but a last flag on them still ends the set.
	assign room = cnt_q < CNT_W'(MAX_POINTS);
	assign sum_nx = room ? sum_q + SUM_W'(sq) : sum_q;
	assign cnt_nx = room ? cnt_q + CNT_W'(1) : cnt_q;

	assign n_ext2 = NSQ_W'(n_q);
	assign n_ext3 = DEN_W'(n_q);
	assign nsqm1_ext = DEN_W'(nsq_q - NSQ_W'(1));
	assign num3 = {2'b00, s_q} + {1'b0, s_q, 1'b0};
	assign den_ext = DIV_W'(den_q);
	assign ge = rem_q >= dsh_q;

	assign stat.few = n_q < CNT_W'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.snap) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.acc) begin
			cnt_q <= cnt_nx;
			sum_q <= sum_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			n_q <= cnt_nx;
			s_q <= sum_nx;
		end
		if (cmd.mul1) begin
			nsq_q <= n_ext2 * n_ext2;
		end
		if (cmd.mul2) begin
			den_q <= n_ext3 * nsqm1_ext;
			rem_q <= DIV_W'({num3, srcc_pkg::QUO_W'(0)});
		end
		if (cmd.div_init) begin
			sat_q <= rem_q >= (den_ext << srcc_pkg::QUO_W);
			dsh_q <= den_ext << (srcc_pkg::QUO_W - 1);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[srcc_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.out_load) begin
			few_q <= stat.few;
			if (stat.few) begin
				rho_q <= '0;
			end else if (sat_q) begin
				rho_q <= srcc_pkg::RHO_MIN;
			end else begin
				rho_q <= srcc_pkg::RHO_ONE - srcc_pkg::RHO_W'(quot_q);
			end
		end
	end

	assign rho = rho_q;
	assign too_few_points = few_q;

endmodule

FILE: sv/srcc_ctrl.sv
`include "spearman_rank_correlation_defines.svh"

module srcc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  srcc_pkg::srcc_stat_t  stat,
	output srcc_pkg::srcc_cmd_t   cmd
);

	localparam logic [2:0] ST_ACC  = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]                   state_q;
	logic [2:0]                   state_nx;
	logic [srcc_pkg::STEP_W-1:0]  step_q;
	logic                         out_valid_q;
	logic                         in_take;
	logic                         out_free;

	assign in_stall = state_q != ST_ACC;
	assign in_take = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		case (state_q)
			ST_ACC: begin
				cmd.acc = in_take && !last;
				cmd.snap = in_take && last;
				if (in_take && last) begin
					state_nx = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				// A set of fewer than two pairs skips the division entirely.
				state_nx = stat.few ? ST_DONE : ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = ST_CHK;
			end
			ST_CHK: begin
				cmd.div_init = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.out_load = out_free;
				if (out_free) begin
					state_nx = ST_ACC;
				end
			end
			default: begin
				state_nx = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_init) begin
				step_q <= srcc_pkg::STEP_W'(srcc_pkg::QUO_W - 1);
			end else if (cmd.div_step) begin
				step_q <= step_q - srcc_pkg::STEP_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`SRCC_ASSERT_NEXT(a_last_starts_calc, in_valid && !in_stall && last, state_q == ST_MUL1)
	`SRCC_ASSERT_NEXT(a_div_ends, state_q == ST_DIV && step_q == '0, state_q == ST_DONE)
	`SRCC_ASSERT_NEXT(a_result_held, state_q == ST_DONE && out_valid_q && out_stall,
		state_q == ST_DONE && out_valid_q)
	`SRCC_ASSERT_NOW(a_load_when_free, cmd.out_load, !out_valid_q || !out_stall)

endmodule
